### hw/rtl/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg: shared types and constants of the tile map collision engine
// Grid geometry, request kinds, contact sides, register indexes and helpers.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 32;
  localparam int TILE_BITS  = 8;
  localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_BITS  = $clog2(GRID_DEPTH);

  // tile size register width and divider geometry
  localparam int TS_W   = 7;
  localparam int DIVD_W = 14;
  localparam int DIVM_W = DIVD_W - 1;

  // signed tile and pixel coordinate inside the engine
  localparam int CRD_W  = 15;
  localparam int PROD_W = 2 * CRD_W;

  localparam int BOX_INSET  = 4;
  localparam int SNAP_SLACK = 4;

  localparam logic [TILE_BITS-1:0] RUN_A_LO = TILE_BITS'(15);
  localparam logic [TILE_BITS-1:0] RUN_A_HI = TILE_BITS'(18);
  localparam logic [TILE_BITS-1:0] RUN_B_LO = TILE_BITS'(10);
  localparam logic [TILE_BITS-1:0] RUN_B_HI = TILE_BITS'(12);

  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_LEFT   = 3'd1;
  localparam logic [2:0] KIND_RIGHT  = 3'd2;
  localparam logic [2:0] KIND_DOWN   = 3'd3;
  localparam logic [2:0] KIND_UP     = 3'd4;
  localparam logic [2:0] KIND_BULLET = 3'd5;
  localparam logic [2:0] KIND_CIRCLE = 3'd6;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam logic [2:0] DIR_LEFT   = 3'd0;
  localparam logic [2:0] DIR_RIGHT  = 3'd1;
  localparam logic [2:0] DIR_TOP    = 3'd2;
  localparam logic [2:0] DIR_BOTTOM = 3'd3;
  localparam logic [2:0] DIR_NONE   = 3'd4;

  localparam logic [1:0] CFG_TILE_SIZE  = 2'd0;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    logic                  en;
    logic                  layer;
    logic [ADDR_BITS-1:0]  addr;
    logic [TILE_BITS-1:0]  data;
  } grid_wr_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(crd_t col, crd_t row);
    int a;
    a = int'(row) * MAX_COLS + int'(col);
    return ADDR_BITS'(a);
  endfunction

  function automatic logic in_map(crd_t col, crd_t row, logic [6:0] w, logic [5:0] h);
    return (col >= 0) && (row >= 0) && (col < crd_t'(w)) && (row < crd_t'(h));
  endfunction

endpackage

### hw/rtl/tmc_div.sv
// ----------------------------------------------------------------------------
// tmc_div: shared restoring divider
// Signed dividend by unsigned nonzero divisor, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tmc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [tmc_pkg::DIVD_W-1:0] dividend,
  input  logic [tmc_pkg::TS_W-1:0]         divisor,
  output logic                             done,
  output logic signed [tmc_pkg::DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(tmc_pkg::DIVM_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [tmc_pkg::TS_W-1:0]    rem_r, rem_nxt;
  logic [tmc_pkg::DIVM_W-1:0]  quo_r, quo_nxt;
  logic                        neg_r, neg_nxt;
  logic [tmc_pkg::TS_W:0]      trial;
  logic [tmc_pkg::DIVD_W-1:0]  mag;

  assign mag   = dividend[tmc_pkg::DIVD_W-1] ? tmc_pkg::DIVD_W'(-dividend)
                                             : tmc_pkg::DIVD_W'(dividend);
  assign trial = {rem_r, quo_r[tmc_pkg::DIVM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(tmc_pkg::DIVM_W);
      rem_nxt  = '0;
      quo_nxt  = mag[tmc_pkg::DIVM_W-1:0];
      neg_nxt  = dividend[tmc_pkg::DIVD_W-1];
    end else if (busy_r) begin
      // shift one dividend bit into the remainder, subtract when it fits
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = tmc_pkg::TS_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[tmc_pkg::DIVM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[tmc_pkg::TS_W-1:0];
        quo_nxt = {quo_r[tmc_pkg::DIVM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

### hw/rtl/tmc_grid.sv
// ----------------------------------------------------------------------------
// tmc_grid: solid and stairs tile memories
// One write port, one registered read port, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module tmc_grid (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tmc_pkg::grid_wr_t                 wr,
  input  logic                              rd_layer,
  input  logic [tmc_pkg::ADDR_BITS-1:0]     rd_addr,
  output logic [tmc_pkg::TILE_BITS-1:0]     rd_data,
  output logic                              clr_busy
);

  logic [tmc_pkg::TILE_BITS-1:0] solid_mem  [tmc_pkg::GRID_DEPTH];
  logic [tmc_pkg::TILE_BITS-1:0] stairs_mem [tmc_pkg::GRID_DEPTH];

  logic                          clr_busy_r;
  logic [tmc_pkg::ADDR_BITS-1:0] clr_cnt_r;
  logic [tmc_pkg::TILE_BITS-1:0] rd_solid_r, rd_stairs_r;
  logic                          rd_layer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + tmc_pkg::ADDR_BITS'(1);
      if (clr_cnt_r == tmc_pkg::ADDR_BITS'(tmc_pkg::GRID_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      solid_mem[clr_cnt_r]  <= '0;
      stairs_mem[clr_cnt_r] <= '0;
    end else if (wr.en) begin
      if (wr.layer) begin
        stairs_mem[wr.addr] <= wr.data;
      end else begin
        solid_mem[wr.addr] <= wr.data;
      end
    end
    rd_solid_r  <= solid_mem[rd_addr];
    rd_stairs_r <= stairs_mem[rd_addr];
    rd_layer_r  <= rd_layer;
  end

  assign rd_data  = rd_layer_r ? rd_stairs_r : rd_solid_r;
  assign clr_busy = clr_busy_r;

endmodule

### hw/rtl/tile_map_collision_engine.sv
// ----------------------------------------------------------------------------
// tile_map_collision_engine: tile grid collision tests
// Tile writes, box tests, bullet tests with breakable runs, and a circle scan
// of the solid grid, run by one sequencer over a shared divider and multiplier.
//
//   channel | direction | fields
//   in_     | slave     | tuser: kind, layer; tdata: request fields
//   out_    | master    | tdata: hit, adjusted_y, direction
//   cfg_    | write     | tile_size, map_width, map_height
//
// Write: a write step, then the result. Box and bullet tests: three divisions,
// a multiply and a setup step, then a read and a check per tile walked (plus
// a clear step per cell on a breakable hit) and a step to load the result.
// Circle: a squared radius step, a read and an occupancy check per tile, with
// distance, dx and dy squaring and compare steps for an occupied tile, and a
// wrap step per row. After reset a clearing pass of all 2048 cells precedes any request.
// in_tready is high only while the sequencer is idle; the result register
// holds its beat until out_tready.
// ----------------------------------------------------------------------------
module tile_map_collision_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] kind, [3] layer
  input  logic [3:0]  in_tuser,
  // [11:0] pos_x, [23:12] pos_y, [31:24] size_x, [39:32] size_y,
  // [52:40] cur_y, [58:53] row_offset, [66:59] radius, [72:67] tile_col,
  // [77:73] tile_row, [85:78] tile_value
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] hit, [13:1] adjusted_y, [16:14] direction
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata
);

  localparam int CW = tmc_pkg::CRD_W;
  localparam int PW = tmc_pkg::PROD_W;
  localparam int DW = tmc_pkg::DIVD_W;
  localparam int TB = tmc_pkg::TILE_BITS;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_WRITE    = 16'h0002,
    S_DIV_GO   = 16'h0004,
    S_DIV_WAIT = 16'h0008,
    S_MUL      = 16'h0010,
    S_SETUP    = 16'h0020,
    S_RD       = 16'h0040,
    S_CHK      = 16'h0080,
    S_CLR      = 16'h0100,
    S_R2       = 16'h0200,
    S_CIR_RD   = 16'h0400,
    S_CIR_DX   = 16'h0800,
    S_CIR_SQX  = 16'h1000,
    S_CIR_SQY  = 16'h2000,
    S_CIR_CMP  = 16'h4000,
    S_DONE     = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] tile_size_r, map_width_r;
  logic [5:0] map_height_r;
  logic [6:0] ts_eff, w_eff;
  logic [5:0] h_eff;

  logic [2:0]  kind_r, kind_nxt;
  logic        layer_r, layer_nxt;
  logic [11:0] px_r, px_nxt, py_r, py_nxt;
  logic [7:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [12:0] cy_r, cy_nxt;
  logic [5:0]  roff_r, roff_nxt;
  logic [7:0]  rad_r, rad_nxt;
  logic [5:0]  tcol_r, tcol_nxt;
  logic [4:0]  trow_r, trow_nxt;
  logic [7:0]  tval_r, tval_nxt;

  logic [1:0]  div_idx_r, div_idx_nxt;
  logic signed [DW-1:0] q0_r, q0_nxt, q1_r, q1_nxt, q2_r, q2_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt, sq_r, sq_nxt, r2_r, r2_nxt;
  logic        cond_r, cond_nxt;
  logic signed [12:0] adjc_r, adjc_nxt;
  tmc_pkg::crd_t fix_r, fix_nxt, k_r, k_nxt, kend_r, kend_nxt;
  tmc_pkg::crd_t c_r, c_nxt, cend_r, cend_nxt;
  logic        inmap_r, inmap_nxt;
  logic [6:0]  ci_r, ci_nxt;
  logic [5:0]  cj_r, cj_nxt;
  tmc_pkg::crd_t rx_r, rx_nxt, ry_r, ry_nxt, dx_r, dx_nxt, dy_r, dy_nxt;

  logic        hit_r, hit_nxt;
  logic signed [12:0] adj_r, adj_nxt;
  logic [2:0]  dir_r, dir_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r, out_hit_nxt;
  logic signed [12:0] out_adj_r, out_adj_nxt;
  logic [2:0]  out_dir_r, out_dir_nxt;

  // shared units
  logic                 div_start, div_done;
  logic signed [DW-1:0] div_dvd, div_quo;
  tmc_pkg::crd_t        mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  tmc_pkg::grid_wr_t            gwr;
  logic                         rd_layer;
  logic [tmc_pkg::ADDR_BITS-1:0] rd_addr;
  logic [TB-1:0]                rd_data;
  logic                         clr_busy;

  logic signed [DW-1:0] px_s, py_s, sx_s, sy_s;
  tmc_pkg::crd_t ts_c, cx_c, cyc_c, loop_col, loop_row, k_start, k_stop, t_c;
  logic signed [PW:0] snap_v, dist_v;
  logic [TB-1:0] tile;
  logic          accept;

  assign ts_eff = (tile_size_r == 7'd0) ? 7'd1 : tile_size_r;
  assign w_eff  = (int'(map_width_r) > tmc_pkg::MAX_COLS) ? 7'(tmc_pkg::MAX_COLS) : map_width_r;
  assign h_eff  = (int'(map_height_r) > tmc_pkg::MAX_ROWS) ? 6'(tmc_pkg::MAX_ROWS)
                                                          : map_height_r;

  assign px_s = DW'($signed({1'b0, px_r}));
  assign py_s = DW'($signed({1'b0, py_r}));
  assign sx_s = DW'($signed({1'b0, sx_r}));
  assign sy_s = DW'($signed({1'b0, sy_r}));
  assign ts_c = CW'($signed({1'b0, ts_eff}));
  assign cx_c = CW'($signed({1'b0, px_r}));
  assign cyc_c = CW'($signed({1'b0, py_r}));

  assign in_tready = (state_r == S_IDLE) && !clr_busy;
  assign accept    = in_tvalid && in_tready;

  // dividend for the current division step
  always_comb begin
    div_dvd = py_s;
    case (kind_r)
      tmc_pkg::KIND_LEFT, tmc_pkg::KIND_RIGHT: begin
        if (div_idx_r == 2'd0) begin
          div_dvd = (kind_r == tmc_pkg::KIND_LEFT) ? px_s + DW'(tmc_pkg::BOX_INSET)
                                                   : px_s + sx_s - DW'(tmc_pkg::BOX_INSET + 1);
        end else if (div_idx_r == 2'd1) begin
          div_dvd = py_s;
        end else begin
          div_dvd = py_s + sy_s - DW'(1);
        end
      end
      tmc_pkg::KIND_DOWN, tmc_pkg::KIND_UP: begin
        if (div_idx_r == 2'd0) begin
          div_dvd = px_s + DW'(tmc_pkg::BOX_INSET);
        end else if (div_idx_r == 2'd1) begin
          div_dvd = px_s + sx_s - DW'(tmc_pkg::BOX_INSET + 1);
        end else begin
          div_dvd = (kind_r == tmc_pkg::KIND_DOWN) ? py_s + sy_s - DW'(1) : py_s;
        end
      end
      tmc_pkg::KIND_BULLET: begin
        if (div_idx_r == 2'd0) begin
          div_dvd = px_s;
        end else if (div_idx_r == 2'd1) begin
          div_dvd = px_s + sx_s - DW'(1);
        end else begin
          div_dvd = py_s;
        end
      end
      default: div_dvd = py_s;
    endcase
  end

  // multiplier operands by phase
  always_comb begin
    mul_a = ts_c;
    mul_b = CW'(q2_r);
    case (state_r)
      S_R2: begin
        mul_a = CW'($signed({1'b0, rad_r}));
        mul_b = CW'($signed({1'b0, rad_r}));
      end
      S_CIR_SQX: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      S_CIR_SQY: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      default: begin
        mul_a = ts_c;
        mul_b = CW'(q2_r);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign loop_col = (kind_r == tmc_pkg::KIND_LEFT || kind_r == tmc_pkg::KIND_RIGHT) ? fix_r : k_r;
  assign loop_row = (kind_r == tmc_pkg::KIND_LEFT || kind_r == tmc_pkg::KIND_RIGHT) ? k_r : fix_r;
  assign tile     = inmap_r ? rd_data : '0;
  assign t_c      = CW'($signed({1'b0, tile}));

  assign snap_v = (PW+1)'(cy_r) + (PW+1)'(sy_s) - (PW+1)'(prod_r);
  assign dist_v = (PW+1)'(sq_r) + (PW+1)'(prod_r);

  always_comb begin
    k_start = CW'(q1_r);
    k_stop  = CW'(q2_r);
    case (kind_r)
      tmc_pkg::KIND_DOWN, tmc_pkg::KIND_UP: begin
        k_start = CW'(q0_r);
        k_stop  = CW'(q1_r);
      end
      tmc_pkg::KIND_BULLET: begin
        k_start = CW'(q0_r) + CW'(1);
        k_stop  = CW'(q1_r) + CW'(1);
      end
      default: begin
        k_start = CW'(q1_r);
        k_stop  = CW'(q2_r);
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    layer_nxt   = layer_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    cy_nxt      = cy_r;
    roff_nxt    = roff_r;
    rad_nxt     = rad_r;
    tcol_nxt    = tcol_r;
    trow_nxt    = trow_r;
    tval_nxt    = tval_r;
    div_idx_nxt = div_idx_r;
    q0_nxt      = q0_r;
    q1_nxt      = q1_r;
    q2_nxt      = q2_r;
    prod_nxt    = prod_r;
    sq_nxt      = sq_r;
    r2_nxt      = r2_r;
    cond_nxt    = cond_r;
    adjc_nxt    = adjc_r;
    fix_nxt     = fix_r;
    k_nxt       = k_r;
    kend_nxt    = kend_r;
    c_nxt       = c_r;
    cend_nxt    = cend_r;
    inmap_nxt   = inmap_r;
    ci_nxt      = ci_r;
    cj_nxt      = cj_r;
    rx_nxt      = rx_r;
    ry_nxt      = ry_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    hit_nxt     = hit_r;
    adj_nxt     = adj_r;
    dir_nxt     = dir_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_hit_nxt   = out_hit_r;
    out_adj_nxt   = out_adj_r;
    out_dir_nxt   = out_dir_r;
    div_start   = 1'b0;
    gwr.en      = 1'b0;
    gwr.layer   = 1'b0;
    gwr.addr    = tmc_pkg::cell_addr(c_r, fix_r);
    gwr.data    = '0;
    rd_layer    = 1'b0;
    rd_addr     = tmc_pkg::cell_addr(loop_col, loop_row);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_tuser[2:0];
          layer_nxt = in_tuser[3];
          px_nxt    = in_tdata[11:0];
          py_nxt    = in_tdata[23:12];
          sx_nxt    = in_tdata[31:24];
          sy_nxt    = in_tdata[39:32];
          cy_nxt    = $signed(in_tdata[52:40]);
          roff_nxt  = in_tdata[58:53];
          rad_nxt   = in_tdata[66:59];
          tcol_nxt  = in_tdata[72:67];
          trow_nxt  = in_tdata[77:73];
          tval_nxt  = in_tdata[85:78];
          hit_nxt   = 1'b0;
          adj_nxt   = $signed(in_tdata[52:40]);
          dir_nxt   = tmc_pkg::DIR_NONE;
          div_idx_nxt = 2'd0;
          ci_nxt    = '0;
          cj_nxt    = '0;
          rx_nxt    = '0;
          ry_nxt    = '0;
          case (in_tuser[2:0])
            tmc_pkg::KIND_WRITE:  state_nxt = S_WRITE;
            tmc_pkg::KIND_CIRCLE: state_nxt = S_R2;
            tmc_pkg::KIND_UNUSED: state_nxt = S_DONE;
            default:              state_nxt = S_DIV_GO;
          endcase
        end
      end
      S_WRITE: begin
        gwr.en    = tmc_pkg::in_map(CW'(tcol_r), CW'(trow_r), w_eff, h_eff);
        gwr.layer = layer_r;
        gwr.addr  = tmc_pkg::cell_addr(CW'(tcol_r), CW'(trow_r));
        gwr.data  = TB'(tval_r);
        state_nxt = S_DONE;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (div_idx_r)
            2'd0:    q0_nxt = div_quo;
            2'd1:    q1_nxt = div_quo;
            default: q2_nxt = div_quo;
          endcase
          if (div_idx_r == 2'd2) begin
            state_nxt = S_MUL;
          end else begin
            div_idx_nxt = div_idx_r + 2'd1;
            state_nxt   = S_DIV_GO;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        k_nxt    = k_start;
        kend_nxt = k_stop;
        cond_nxt = (snap_v <= (PW+1)'(tmc_pkg::SNAP_SLACK));
        adjc_nxt = (kind_r == tmc_pkg::KIND_DOWN) ? 13'(prod_r - PW'(sy_s))
                                                  : 13'(prod_r + PW'(ts_c));
        case (kind_r)
          tmc_pkg::KIND_LEFT:   fix_nxt = CW'(q0_r);
          tmc_pkg::KIND_RIGHT:  fix_nxt = CW'(q0_r) - CW'(layer_r);
          tmc_pkg::KIND_BULLET: fix_nxt = CW'(q2_r) - CW'($signed({1'b0, roff_r})) - CW'(1);
          default:              fix_nxt = CW'(q2_r);
        endcase
        state_nxt = (k_start > k_stop) ? S_DONE : S_RD;
      end
      S_RD: begin
        rd_layer  = (kind_r == tmc_pkg::KIND_BULLET) ? 1'b0 : layer_r;
        inmap_nxt = tmc_pkg::in_map(loop_col, loop_row, w_eff, h_eff);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (tile != '0 &&
            (!(kind_r == tmc_pkg::KIND_DOWN || kind_r == tmc_pkg::KIND_UP) || cond_r)) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
          if (kind_r == tmc_pkg::KIND_DOWN || kind_r == tmc_pkg::KIND_UP) begin
            adj_nxt = adjc_r;
          end
          if (kind_r == tmc_pkg::KIND_BULLET) begin
            // breakable run: clear from its low end to its high end
            if (tile >= tmc_pkg::RUN_A_LO && tile <= tmc_pkg::RUN_A_HI) begin
              c_nxt     = k_r - t_c + CW'(tmc_pkg::RUN_A_LO);
              cend_nxt  = k_r + CW'(tmc_pkg::RUN_A_HI) - t_c;
              state_nxt = S_CLR;
            end else if (tile >= tmc_pkg::RUN_B_LO && tile <= tmc_pkg::RUN_B_HI) begin
              c_nxt     = k_r - t_c + CW'(tmc_pkg::RUN_B_LO);
              cend_nxt  = k_r + CW'(tmc_pkg::RUN_B_HI) - t_c;
              state_nxt = S_CLR;
            end
          end
        end else if (k_r == kend_r) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_RD;
        end
      end
      S_CLR: begin
        gwr.en    = tmc_pkg::in_map(c_r, fix_r, w_eff, h_eff);
        gwr.layer = 1'b0;
        gwr.addr  = tmc_pkg::cell_addr(c_r, fix_r);
        gwr.data  = '0;
        c_nxt     = c_r + CW'(1);
        if (c_r == cend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_R2: begin
        r2_nxt    = mul_p;
        state_nxt = S_CIR_RD;
      end
      S_CIR_RD: begin
        rd_layer = 1'b0;
        rd_addr  = tmc_pkg::cell_addr(CW'(ci_r), CW'(cj_r));
        if (cj_r >= h_eff) begin
          state_nxt = S_DONE;
        end else if (ci_r >= w_eff) begin
          // wrap to the next row
          ci_nxt = '0;
          rx_nxt = '0;
          cj_nxt = cj_r + 6'd1;
          ry_nxt = ry_r + ts_c;
        end else begin
          inmap_nxt = 1'b1;
          state_nxt = S_CIR_DX;
        end
      end
      S_CIR_DX: begin
        if (tile == '0) begin
          ci_nxt    = ci_r + 7'd1;
          rx_nxt    = rx_r + ts_c;
          state_nxt = S_CIR_RD;
        end else begin
          if (cx_c < rx_r) begin
            dx_nxt = cx_c - rx_r;
          end else if (cx_c > rx_r + ts_c) begin
            dx_nxt = cx_c - rx_r - ts_c;
          end else begin
            dx_nxt = '0;
          end
          if (cyc_c < ry_r) begin
            dy_nxt = cyc_c - ry_r;
          end else if (cyc_c > ry_r + ts_c) begin
            dy_nxt = cyc_c - ry_r - ts_c;
          end else begin
            dy_nxt = '0;
          end
          state_nxt = S_CIR_SQX;
        end
      end
      S_CIR_SQX: begin
        prod_nxt  = mul_p;
        state_nxt = S_CIR_SQY;
      end
      S_CIR_SQY: begin
        sq_nxt    = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_CIR_CMP;
      end
      S_CIR_CMP: begin
        if (dist_v > (PW+1)'(r2_r)) begin
          ci_nxt    = ci_r + 7'd1;
          rx_nxt    = rx_r + ts_c;
          state_nxt = S_CIR_RD;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
          if (dx_r <= 0 && dy_r <= 0) begin
            dir_nxt = (dx_r <= dy_r) ? tmc_pkg::DIR_LEFT : tmc_pkg::DIR_TOP;
          end else if (dx_r >= 0 && dy_r >= 0) begin
            dir_nxt = (dx_r >= dy_r) ? tmc_pkg::DIR_RIGHT : tmc_pkg::DIR_BOTTOM;
          end else if (dx_r >= 0) begin
            dir_nxt = (dx_r >= -dy_r) ? tmc_pkg::DIR_RIGHT : tmc_pkg::DIR_TOP;
          end else begin
            dir_nxt = (dy_r <= -dx_r) ? tmc_pkg::DIR_LEFT : tmc_pkg::DIR_BOTTOM;
          end
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_adj_nxt   = adj_r;
          out_dir_nxt   = dir_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      tile_size_r  <= 7'd16;
      map_width_r  <= 7'd32;
      map_height_r <= 6'd26;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          tmc_pkg::CFG_TILE_SIZE:  tile_size_r  <= cfg_wdata;
          tmc_pkg::CFG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
          tmc_pkg::CFG_MAP_HEIGHT: map_height_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
    end
    kind_r    <= kind_nxt;
    layer_r   <= layer_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    cy_r      <= cy_nxt;
    roff_r    <= roff_nxt;
    rad_r     <= rad_nxt;
    tcol_r    <= tcol_nxt;
    trow_r    <= trow_nxt;
    tval_r    <= tval_nxt;
    div_idx_r <= div_idx_nxt;
    q0_r      <= q0_nxt;
    q1_r      <= q1_nxt;
    q2_r      <= q2_nxt;
    prod_r    <= prod_nxt;
    sq_r      <= sq_nxt;
    r2_r      <= r2_nxt;
    cond_r    <= cond_nxt;
    adjc_r    <= adjc_nxt;
    fix_r     <= fix_nxt;
    k_r       <= k_nxt;
    kend_r    <= kend_nxt;
    c_r       <= c_nxt;
    cend_r    <= cend_nxt;
    inmap_r   <= inmap_nxt;
    ci_r      <= ci_nxt;
    cj_r      <= cj_nxt;
    rx_r      <= rx_nxt;
    ry_r      <= ry_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    hit_r     <= hit_nxt;
    adj_r     <= adj_nxt;
    dir_r     <= dir_nxt;
    out_hit_r <= out_hit_nxt;
    out_adj_r <= out_adj_nxt;
    out_dir_r <= out_dir_nxt;
  end

  tmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (ts_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  tmc_grid u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (gwr),
    .rd_layer (rd_layer),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_dir_r, out_adj_r, out_hit_r};

`ifndef SYNTHESIS
  a_dir_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_dir_r != tmc_pkg::DIR_NONE) |-> out_hit_r)
    else $error("contact side reported without a hit");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("request accepted during grid clearing");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    gwr.en |-> (state_r == S_WRITE || state_r == S_CLR))
    else $error("grid write outside a write or clear step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after an accepted beat");
`endif

endmodule
